// ===== rtl/abct_pkg.sv =====
// shared types and constants for the aux bus command transaction block
// frame codes, queue word layout and controller state encodings
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package abct_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_ISSUE  = 2'd0;
    localparam logic [1:0] OP_RXBYTE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // outcome status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_BADSUM   = 2'd3;

    // result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // configuration register indexes
    localparam logic CFG_SOURCE_ID = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

    localparam logic [7:0]  SOURCE_ID_RESET = 8'd13;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

    // frame layout
    localparam logic [7:0] PREAMBLE   = 8'h3B;
    localparam logic [7:0] HDR_LEN    = 8'd3;
    localparam logic [7:0] END_INIT   = 8'd10;
    localparam logic [7:0] LEN_MIN    = 8'd3;
    localparam logic [7:0] LEN_MAX    = 8'd253;
    localparam logic [7:0] END_OFFSET = 8'd2;

    // reply byte positions
    localparam logic [7:0] POS_PREAMBLE = 8'd0;
    localparam logic [7:0] POS_LEN      = 8'd1;
    localparam logic [7:0] POS_DEST     = 8'd2;
    localparam logic [7:0] POS_SRC      = 8'd3;
    localparam logic [7:0] POS_CMD      = 8'd4;
    localparam logic [7:0] POS_DATA     = 8'd5;

    // transmit byte indexes within a frame
    localparam logic [3:0] TX_LEN  = 4'd1;
    localparam logic [3:0] TX_SRC  = 4'd2;
    localparam logic [3:0] TX_DEST = 4'd3;
    localparam logic [3:0] TX_CMD  = 4'd4;
    localparam logic [3:0] TX_DATA = 4'd5;

    localparam int DATA_W       = 24;
    localparam int REPLY_DATA_W = 40;
    localparam int QUEUE_DEPTH  = 2;

    // one classified word between front end and engine
    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        dest;
        logic [7:0]        cmd;
        logic [1:0]        nbytes;
        logic [DATA_W-1:0] data;     // left aligned, first byte on top
        logic [7:0]        part_sum; // frame sum without preamble and source id
        logic [7:0]        rx_byte;
    } t_qent;

    typedef enum logic [1:0] {
        BS_FETCH = 2'b01,
        BS_SEND  = 2'b10
    } t_bstate;

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_WAIT = 2'b10
    } t_phase;

endpackage

`default_nettype wire

// ===== rtl/abct_front.sv =====
// front end: accepts input words, drops unknown operations, prepares issue words
// clips and aligns command data and sums the frame bytes known here
// depends on abct_pkg
`timescale 1ns / 1ps
`default_nettype none

module abct_front import abct_pkg::*; #(
    parameter int MAX_DATA_BYTES = 3
) (
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_operation,
    input  wire logic [7:0]        i_dest_id,
    input  wire logic [7:0]        i_command,
    input  wire logic [1:0]        i_data_len,
    input  wire logic [DATA_W-1:0] i_data_bytes,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_qent                  o_entry
);

    localparam logic [1:0] MaxN = 2'(MAX_DATA_BYTES);

    logic [1:0]        w_n;
    logic [DATA_W-1:0] w_al;
    logic [7:0]        w_lenb;
    logic              w_known;

    assign w_n = (i_data_len > MaxN) ? MaxN : i_data_len;

    // first byte to send goes to the top, unused bytes read as zero
    always_comb begin
        case (w_n)
            2'd0:    w_al = '0;
            2'd1:    w_al = {i_data_bytes[7:0], 16'h0000};
            2'd2:    w_al = {i_data_bytes[15:0], 8'h00};
            default: w_al = i_data_bytes;
        endcase
    end

    assign w_lenb  = HDR_LEN + {6'b0, w_n};
    assign w_known = (i_operation == OP_ISSUE) || (i_operation == OP_RXBYTE) ||
                     (i_operation == OP_TICK);

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && w_known;

    always_comb begin
        o_entry.op       = i_operation;
        o_entry.dest     = i_dest_id;
        o_entry.cmd      = i_command;
        o_entry.nbytes   = w_n;
        o_entry.data     = w_al;
        o_entry.part_sum = w_lenb + i_dest_id + i_command + w_al[23:16] + w_al[15:8]
                         + w_al[7:0];
        o_entry.rx_byte  = i_rx_byte;
    end

endmodule

`default_nettype wire

// ===== rtl/abct_queue.sv =====
// short word queue between front end and engine
// register based, one push and one pop per cycle, push only while not full
// depends on abct_pkg
`timescale 1ns / 1ps
`default_nettype none

module abct_queue import abct_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_entry,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_nonempty,
    output t_qent      o_entry
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] Full    = CntW'(QUEUE_DEPTH);

    t_qent           r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic            w_wr_en;
    logic            w_rd_en;

    assign o_full     = (r_cnt == Full);
    assign o_nonempty = (r_cnt != '0);
    assign o_entry    = r_mem[r_rd];
    assign w_wr_en    = i_push && !o_full;
    assign w_rd_en    = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd_en && !w_wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/abct_back.sv =====
// engine: sends frames byte by byte, parses replies, runs the timeout
// holds the transaction state and the output register
// depends on abct_pkg
`timescale 1ns / 1ps
`default_nettype none

module abct_back import abct_pkg::*; #(
    parameter int REPLY_BUFFER_BYTES = 5
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [7:0]              i_source_id,
    input  wire logic [15:0]             i_timeout_ticks,
    input  wire logic                    i_q_nonempty,
    input  wire t_qent                   i_entry,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic                         o_kind,
    output logic [7:0]                   o_tx_byte,
    output logic                         o_last,
    output logic [1:0]                   o_status,
    output logic [2:0]                   o_reply_len,
    output logic [REPLY_DATA_W-1:0]      o_reply_data
);

    localparam logic [7:0] RbBytes  = 8'(REPLY_BUFFER_BYTES);
    localparam logic [7:0] StoreEnd = 8'(5 + REPLY_BUFFER_BYTES);

    t_bstate r_state, n_state;
    t_phase  r_phase, n_phase;
    logic [7:0]              r_pos, n_pos;
    logic [7:0]              r_end, n_end;
    logic [7:0]              r_sum, n_sum;
    logic [7:0]              r_dest, n_dest;
    logic [7:0]              r_cmd, n_cmd;
    logic [15:0]             r_ticks, n_ticks;
    logic [REPLY_DATA_W-1:0] r_acc, n_acc;
    logic [3:0]              r_tx_idx, n_tx_idx;
    logic [1:0]              r_tx_n, n_tx_n;
    logic [DATA_W-1:0]       r_tx_data, n_tx_data;
    logic [7:0]              r_tx_part, n_tx_part;

    logic                    r_out_valid;
    logic                    r_kind;
    logic [7:0]              r_tx_byte;
    logic                    r_last;
    logic [1:0]              r_status;
    logic [2:0]              r_rlen;
    logic [REPLY_DATA_W-1:0] r_rdata;

    logic                    w_slot;
    logic                    w_emit;
    logic                    e_kind;
    logic [7:0]              e_byte;
    logic                    e_last;
    logic [1:0]              e_status;
    logic [2:0]              e_len;
    logic [REPLY_DATA_W-1:0] e_data;

    logic [7:0] w_b;
    logic       w_bad;
    logic [7:0] w_neg_sum;
    logic [7:0] w_dlen;
    logic [7:0] w_rlen;
    logic [3:0] w_ck_idx;

    assign w_slot = !r_out_valid || i_out_ready;
    assign w_b    = i_entry.rx_byte;

    // header checks of a reply byte
    assign w_bad = ((r_pos == POS_PREAMBLE) && (w_b != PREAMBLE)) ||
                   ((r_pos == POS_LEN) && ((w_b < LEN_MIN) || (w_b > LEN_MAX))) ||
                   ((r_pos == POS_DEST) && (w_b != r_dest)) ||
                   ((r_pos == POS_SRC) && (w_b != i_source_id)) ||
                   ((r_pos == POS_CMD) && (w_b != r_cmd));

    assign w_neg_sum = 8'd0 - r_sum;
    assign w_dlen    = r_end - POS_DATA;
    assign w_rlen    = (w_dlen > RbBytes) ? RbBytes : w_dlen;
    assign w_ck_idx  = TX_DATA + {2'b00, r_tx_n};

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_end     = r_end;
        n_sum     = r_sum;
        n_dest    = r_dest;
        n_cmd     = r_cmd;
        n_ticks   = r_ticks;
        n_acc     = r_acc;
        n_tx_idx  = r_tx_idx;
        n_tx_n    = r_tx_n;
        n_tx_data = r_tx_data;
        n_tx_part = r_tx_part;
        o_pop     = 1'b0;
        w_emit    = 1'b0;
        e_kind    = KIND_BYTE;
        e_byte    = 8'd0;
        e_last    = 1'b0;
        e_status  = ST_OK;
        e_len     = 3'd0;
        e_data    = '0;
        case (r_state)
            BS_FETCH: begin
                if (i_q_nonempty && w_slot) begin
                    o_pop = 1'b1;
                    case (i_entry.op)
                        OP_ISSUE: begin
                            // a new issue drops any pending reply
                            w_emit    = 1'b1;
                            e_byte    = PREAMBLE;
                            n_state   = BS_SEND;
                            n_tx_idx  = TX_LEN;
                            n_tx_n    = i_entry.nbytes;
                            n_tx_data = i_entry.data;
                            n_tx_part = i_entry.part_sum;
                            n_phase   = PH_WAIT;
                            n_pos     = POS_PREAMBLE;
                            n_end     = END_INIT;
                            n_sum     = 8'd0;
                            n_dest    = i_entry.dest;
                            n_cmd     = i_entry.cmd;
                            n_ticks   = i_timeout_ticks;
                            n_acc     = '0;
                        end
                        OP_RXBYTE: begin
                            if (r_phase == PH_WAIT) begin
                                if ((r_pos != POS_PREAMBLE) && (r_pos != r_end)) begin
                                    n_sum = r_sum + w_b;
                                end
                                if (r_pos == POS_LEN) begin
                                    n_end = w_b + END_OFFSET;
                                end
                                if (w_bad) begin
                                    w_emit   = 1'b1;
                                    e_kind   = KIND_REPLY;
                                    e_status = ST_MISMATCH;
                                    n_phase  = PH_IDLE;
                                end else if (r_pos == r_end) begin
                                    w_emit  = 1'b1;
                                    e_kind  = KIND_REPLY;
                                    n_phase = PH_IDLE;
                                    if (w_b == w_neg_sum) begin
                                        e_status = ST_OK;
                                        e_len    = w_rlen[2:0];
                                        e_data   = r_acc;
                                    end else begin
                                        e_status = ST_BADSUM;
                                    end
                                end else begin
                                    if ((r_pos >= POS_DATA) && (r_pos < StoreEnd)) begin
                                        n_acc = {r_acc[REPLY_DATA_W-9:0], w_b};
                                    end
                                    n_pos = r_pos + 8'd1;
                                end
                            end
                        end
                        OP_TICK: begin
                            if (r_phase == PH_WAIT) begin
                                if (r_ticks <= 16'd1) begin
                                    n_ticks  = 16'd0;
                                    w_emit   = 1'b1;
                                    e_kind   = KIND_REPLY;
                                    e_status = ST_TIMEOUT;
                                    n_phase  = PH_IDLE;
                                end else begin
                                    n_ticks = r_ticks - 16'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BS_SEND: begin
                if (w_slot) begin
                    w_emit   = 1'b1;
                    n_tx_idx = r_tx_idx + 4'd1;
                    if (r_tx_idx == TX_LEN) begin
                        e_byte = HDR_LEN + {6'b0, r_tx_n};
                    end else if (r_tx_idx == TX_SRC) begin
                        e_byte = i_source_id;
                    end else if (r_tx_idx == TX_DEST) begin
                        e_byte = r_dest;
                    end else if (r_tx_idx == TX_CMD) begin
                        e_byte = r_cmd;
                    end else if (r_tx_idx == w_ck_idx) begin
                        e_byte  = 8'd0 - (r_tx_part + i_source_id);
                        e_last  = 1'b1;
                        n_state = BS_FETCH;
                    end else begin
                        e_byte    = r_tx_data[DATA_W-1:DATA_W-8];
                        n_tx_data = {r_tx_data[DATA_W-9:0], 8'h00};
                    end
                end
            end
            default: n_state = BS_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_FETCH;
            r_phase     <= PH_IDLE;
            r_pos       <= 8'd0;
            r_end       <= END_INIT;
            r_sum       <= 8'd0;
            r_dest      <= 8'd0;
            r_cmd       <= 8'd0;
            r_ticks     <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_end   <= n_end;
            r_sum   <= n_sum;
            r_dest  <= n_dest;
            r_cmd   <= n_cmd;
            r_ticks <= n_ticks;
            if (w_slot) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_tx_idx  <= n_tx_idx;
        r_tx_n    <= n_tx_n;
        r_tx_data <= n_tx_data;
        r_tx_part <= n_tx_part;
        if (w_slot && w_emit) begin
            r_kind    <= e_kind;
            r_tx_byte <= e_byte;
            r_last    <= e_last;
            r_status  <= e_status;
            r_rlen    <= e_len;
            r_rdata   <= e_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_tx_byte    = r_tx_byte;
    assign o_last       = r_last;
    assign o_status     = r_status;
    assign o_reply_len  = r_rlen;
    assign o_reply_data = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/aux_bus_command_transaction.sv =====
// top level of the aux bus command transaction block
// holds the configuration registers and joins front end, queue and engine
// depends on abct_pkg, abct_front, abct_queue, abct_back
`timescale 1ns / 1ps
`default_nettype none

// Host side of a checksummed serial command bus. An issue word makes the block
// send a frame as a run of byte results: preamble, length, source, destination,
// command, up to MAX_DATA_BYTES data bytes and a two's-complement checksum
// (last set on it). Received-byte words are then parsed against the expected
// reply header; tick words count down the timeout. Each wait ends in at most
// one outcome result (ok with up to REPLY_BUFFER_BYTES data bytes, timeout,
// mismatch or bad checksum). A new issue drops a pending reply silently. Input
// words go through a two-entry queue into the engine, which handles one word
// at a time and on an issue sends the whole frame, one frame byte per cycle
// into the output register unless the consumer stalls it, so the engine's
// byte sequencer sets the rate. The queue lets input be taken while the
// engine is sending or its output waits on the consumer. Configuration is
// written through a plain write port with no wait state.

module aux_bus_command_transaction import abct_pkg::*; #(
    parameter int MAX_DATA_BYTES     = 3,
    parameter int REPLY_BUFFER_BYTES = 5
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [1:0]              i_operation,
    input  wire logic [7:0]              i_dest_id,
    input  wire logic [7:0]              i_command,
    input  wire logic [1:0]              i_data_len,
    input  wire logic [DATA_W-1:0]       i_data_bytes,
    input  wire logic [7:0]              i_rx_byte,
    // result channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic                         o_kind,
    output logic [7:0]                   o_tx_byte,
    output logic                         o_last,
    output logic [1:0]                   o_status,
    output logic [2:0]                   o_reply_len,
    output logic [REPLY_DATA_W-1:0]      o_reply_data,
    // configuration write port
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_idx,
    input  wire logic [15:0]             i_cfg_data
);

    // configuration registers
    logic [7:0]  r_source_id;
    logic [15:0] r_timeout_ticks;

    // front end to queue
    logic  w_push;
    t_qent w_push_entry;
    logic  w_q_full;

    // queue to engine
    logic  w_q_nonempty;
    logic  w_pop;
    t_qent w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_id     <= SOURCE_ID_RESET;
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SOURCE_ID: r_source_id     <= i_cfg_data[7:0];
                CFG_TIMEOUT:   r_timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify words, clip data length, precompute frame sum
    abct_front #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_dest_id   (i_dest_id),
        .i_command   (i_command),
        .i_data_len  (i_data_len),
        .i_data_bytes(i_data_bytes),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    // decouples input acceptance from the engine
    abct_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_entry   (w_push_entry),
        .i_pop     (w_pop),
        .o_full    (w_q_full),
        .o_nonempty(w_q_nonempty),
        .o_entry   (w_head)
    );

    // frame sender, reply parser and timeout
    abct_back #(
        .REPLY_BUFFER_BYTES(REPLY_BUFFER_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_source_id    (r_source_id),
        .i_timeout_ticks(r_timeout_ticks),
        .i_q_nonempty   (w_q_nonempty),
        .i_entry        (w_head),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_tx_byte      (o_tx_byte),
        .o_last         (o_last),
        .o_status       (o_status),
        .o_reply_len    (o_reply_len),
        .o_reply_data   (o_reply_data)
    );

endmodule

`default_nettype wire
